// ----- src/brb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package brb_pkg;

  // Ring and block sizing.
  localparam int CAPACITY  = 1024;
  localparam int MAX_BLOCK = 64;
  localparam int PTR_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int LEN_W     = 7;
  localparam int BYTE_W    = 8;
  localparam int CMP_W     = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  // Command queue between front and back; depth is a power of two.
  localparam int QUEUE_DEPTH = 4;
  localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Operation codes on the op field.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_NO_DATA  = 2'd2,
    ST_ZERO_LEN = 2'd3
  } status_t;

  // Work handed from the front to the back.
  typedef struct packed {
    logic              do_store;
    logic              do_status;
    logic              do_read;
    status_t           status;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] data;
  } cmd_t;

  // One result beat waiting in the output buffer.
  typedef struct packed {
    status_t           status;
    logic [BYTE_W-1:0] read_byte;
    logic              byte_valid;
    logic              last;
  } beat_t;

  typedef enum logic {
    BK_IDLE,
    BK_READ
  } back_state_t;

  // Advance a ring pointer, wrapping at the capacity.
  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(CAPACITY - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

`default_nettype wire

// ----- src/brb_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [$clog2(DEPTH)-1:0]      waddr,
  input  wire logic [WIDTH-1:0]              wdata,
  input  wire logic                          re,
  input  wire logic [$clog2(DEPTH)-1:0]      raddr,
  output logic      [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/brb_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module brb_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire brb_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output brb_pkg::cmd_t      head_cmd
);

  brb_pkg::cmd_t                   slots [brb_pkg::QUEUE_DEPTH];
  logic [brb_pkg::QIDX_W-1:0]      wr_ptr;
  logic [brb_pkg::QIDX_W-1:0]      rd_ptr;
  logic [brb_pkg::QCNT_W-1:0]      count;

  assign full       = (count == brb_pkg::QCNT_W'(brb_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = slots[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Command storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ----- src/brb_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module brb_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         accept,
  input  wire logic                         op,
  input  wire logic                         first,
  input  wire logic [brb_pkg::LEN_W-1:0]    block_length,
  input  wire logic [brb_pkg::BYTE_W-1:0]   data_byte,
  output logic                              cmd_push,
  output brb_pkg::cmd_t                     cmd
);

  logic [brb_pkg::CNT_W-1:0] free_count;
  logic [brb_pkg::CNT_W-1:0] free_count_next;
  logic [brb_pkg::LEN_W-1:0] bytes_left;
  logic [brb_pkg::LEN_W-1:0] bytes_left_next;
  logic                      block_accepted;
  logic                      block_accepted_next;

  logic [brb_pkg::CMP_W-1:0] len_wide;
  logic [brb_pkg::CMP_W-1:0] free_wide;
  logic [brb_pkg::CMP_W-1:0] stored_wide;
  logic                      too_long;

  assign len_wide    = brb_pkg::CMP_W'(block_length);
  assign free_wide   = brb_pkg::CMP_W'(free_count);
  assign stored_wide = brb_pkg::CMP_W'(brb_pkg::CAPACITY) - free_wide;
  assign too_long    = (len_wide > brb_pkg::CMP_W'(brb_pkg::MAX_BLOCK));

  // Classify the beat and track space and block progress in item order.
  always_comb begin
    free_count_next     = free_count;
    bytes_left_next     = bytes_left;
    block_accepted_next = block_accepted;
    cmd_push            = 1'b0;
    cmd                 = '0;
    cmd.status          = brb_pkg::ST_OK;
    cmd.len             = block_length;
    cmd.data            = data_byte;
    if (accept) begin
      if (op == brb_pkg::OP_WRITE) begin
        if (first) begin
          cmd_push      = 1'b1;
          cmd.do_status = 1'b1;
          if (block_length == '0) begin
            bytes_left_next     = '0;
            block_accepted_next = 1'b0;
            cmd.status          = brb_pkg::ST_ZERO_LEN;
          end else if (too_long || (len_wide > free_wide)) begin
            bytes_left_next     = block_length - 1'b1;
            block_accepted_next = 1'b0;
            cmd.status          = brb_pkg::ST_NO_SPACE;
          end else begin
            bytes_left_next     = block_length - 1'b1;
            block_accepted_next = 1'b1;
            cmd.do_store        = 1'b1;
            free_count_next     = free_count - 1'b1;
          end
        end else if (bytes_left != '0) begin
          // Later byte of an open block; stray bytes are dropped.
          bytes_left_next = bytes_left - 1'b1;
          if (block_accepted) begin
            cmd_push        = 1'b1;
            cmd.do_store    = 1'b1;
            free_count_next = free_count - 1'b1;
          end
          if (bytes_left == brb_pkg::LEN_W'(1)) begin
            block_accepted_next = 1'b0;
          end
        end
      end else begin
        cmd_push = 1'b1;
        if (block_length == '0) begin
          cmd.do_status = 1'b1;
          cmd.status    = brb_pkg::ST_OK;
        end else if (too_long || (len_wide > stored_wide)) begin
          cmd.do_status = 1'b1;
          cmd.status    = brb_pkg::ST_NO_DATA;
        end else begin
          cmd.do_read     = 1'b1;
          free_count_next = free_count + brb_pkg::CNT_W'(block_length);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_count     <= brb_pkg::CNT_W'(brb_pkg::CAPACITY);
      bytes_left     <= '0;
      block_accepted <= 1'b0;
    end else begin
      free_count     <= free_count_next;
      bytes_left     <= bytes_left_next;
      block_accepted <= block_accepted_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/brb_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module brb_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cmd_valid,
  input  wire brb_pkg::cmd_t                cmd,
  output logic                              cmd_pop,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [1:0]                        status,
  output logic [brb_pkg::BYTE_W-1:0]        read_byte,
  output logic                              byte_valid,
  output logic                              last
);

  brb_pkg::back_state_t           state;
  brb_pkg::back_state_t           state_next;

  logic [brb_pkg::PTR_W-1:0]      put_ptr;
  logic [brb_pkg::PTR_W-1:0]      take_ptr;
  logic [brb_pkg::LEN_W-1:0]      remaining;

  // Stage that lines up with the registered memory read.
  logic                           stg_valid;
  logic                           stg_byte;
  brb_pkg::status_t               stg_status;
  logic                           stg_last;

  // Two-entry output buffer.
  brb_pkg::beat_t                 obuf [2];
  logic                           ohead;
  logic                           otail;
  logic [1:0]                     occ;

  logic                           out_pop;
  logic [1:0]                     fill;
  logic                           slot_ok;
  logic                           ram_we;
  logic                           issue_status;
  logic                           issue_byte;
  logic [brb_pkg::BYTE_W-1:0]     ram_rdata;
  brb_pkg::beat_t                 push_beat;

  // A beat may be issued when the stage and buffer leave room for it.
  assign out_pop = (occ != 2'd0) && !out_stall;
  assign fill    = occ + {1'b0, stg_valid};
  assign slot_ok = (fill < 2'd2) || out_pop;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      brb_pkg::BK_IDLE: begin
        if (cmd_valid && cmd.do_read) begin
          state_next = brb_pkg::BK_READ;
        end
      end
      brb_pkg::BK_READ: begin
        if (slot_ok && (remaining == brb_pkg::LEN_W'(1))) begin
          state_next = brb_pkg::BK_IDLE;
        end
      end
      default: state_next = brb_pkg::BK_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    cmd_pop      = 1'b0;
    ram_we       = 1'b0;
    issue_status = 1'b0;
    issue_byte   = 1'b0;
    case (state)
      brb_pkg::BK_IDLE: begin
        if (cmd_valid && (cmd.do_read || !cmd.do_status || slot_ok)) begin
          cmd_pop      = 1'b1;
          ram_we       = cmd.do_store;
          issue_status = cmd.do_status;
        end
      end
      brb_pkg::BK_READ: begin
        issue_byte = slot_ok;
      end
      default: begin
        cmd_pop = 1'b0;
      end
    endcase
  end

  brb_ram #(
    .WIDTH (brb_pkg::BYTE_W),
    .DEPTH (brb_pkg::CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (put_ptr),
    .wdata (cmd.data),
    .re    (issue_byte),
    .raddr (take_ptr),
    .rdata (ram_rdata)
  );

  // Sequencer registers and ring pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= brb_pkg::BK_IDLE;
      put_ptr   <= '0;
      take_ptr  <= '0;
      remaining <= '0;
      stg_valid <= 1'b0;
    end else begin
      state     <= state_next;
      stg_valid <= issue_status || issue_byte;
      if (ram_we) begin
        put_ptr <= brb_pkg::ptr_next(put_ptr);
      end
      if (issue_byte) begin
        take_ptr  <= brb_pkg::ptr_next(take_ptr);
        remaining <= remaining - 1'b1;
      end else if (cmd_pop && cmd.do_read) begin
        remaining <= cmd.len;
      end
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    stg_byte   <= issue_byte;
    stg_status <= issue_status ? cmd.status : brb_pkg::ST_OK;
    stg_last   <= issue_status || (remaining == brb_pkg::LEN_W'(1));
  end

  // Beat entering the output buffer, with the memory data where it is a byte.
  always_comb begin
    push_beat.status     = stg_status;
    push_beat.read_byte  = stg_byte ? ram_rdata : '0;
    push_beat.byte_valid = stg_byte;
    push_beat.last       = stg_last;
  end

  // Output buffer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      ohead <= 1'b0;
      otail <= 1'b0;
      occ   <= 2'd0;
    end else begin
      if (stg_valid) begin
        otail <= ~otail;
      end
      if (out_pop) begin
        ohead <= ~ohead;
      end
      occ <= occ + {1'b0, stg_valid} - {1'b0, out_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (stg_valid) begin
      obuf[otail] <= push_beat;
    end
  end

  assign out_valid  = (occ != 2'd0);
  assign status     = obuf[ohead].status;
  assign read_byte  = obuf[ohead].read_byte;
  assign byte_valid = obuf[ohead].byte_valid;
  assign last       = obuf[ohead].last;

endmodule

`default_nettype wire

// ----- src/byte_ring_buffer_block_io.sv -----
// Block-oriented circular byte store of 1024 bytes.
// Input channel (in_valid / in_stall): one beat per item. A write block is
// sent as one beat per byte with op low; its first beat has first set and
// carries block_length. A read request (op high) carries the length to take.
// Output channel (out_valid / out_stall): each first write beat gives one
// status beat; a read gives block_length data beats, the final one with last
// set, or a single status beat when the length is zero or over 64 or too few
// bytes are held. Later write beats give nothing.
// Throughput: write beats are taken one per cycle while the command queue is
// not full. A read holds the back end until all its bytes are read, one
// memory read per cycle from the single read port while the output buffer has
// room; a status result waits for room in the output buffer.
// A status result passes from the command queue through the stage register
// into the output buffer; a read byte comes from the registered memory read.
// A four-entry command queue sits between the classifier and the memory
// sequencer, so input beats keep being taken while output is stalled until
// that queue fills; a stalled output beat holds its value.
// Reset empties the store and both queues; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module byte_ring_buffer_block_io (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         op,
  input  wire logic                         first,
  input  wire logic [brb_pkg::LEN_W-1:0]    block_length,
  input  wire logic [brb_pkg::BYTE_W-1:0]   data_byte,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [1:0]                        status,
  output logic [brb_pkg::BYTE_W-1:0]        read_byte,
  output logic                              byte_valid,
  output logic                              last
);

  logic          accept;
  logic          q_push;
  brb_pkg::cmd_t q_in;
  logic          q_full;
  logic          q_pop;
  logic          q_valid;
  brb_pkg::cmd_t q_head;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  brb_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .op           (op),
    .first        (first),
    .block_length (block_length),
    .data_byte    (data_byte),
    .cmd_push     (q_push),
    .cmd          (q_in)
  );

  brb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_head)
  );

  brb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (q_valid),
    .cmd        (q_head),
    .cmd_pop    (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .read_byte  (read_byte),
    .byte_valid (byte_valid),
    .last       (last)
  );

`ifndef NO_ASSERTIONS
  // Data beats only come from successful reads.
  a_byte_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_valid |-> status == brb_pkg::ST_OK)
    else $error("data beat with error status");

  // A status-only result is always the final beat of its item.
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> last)
    else $error("status beat without last");

  // The sequencer never takes from an empty queue.
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("command queue popped while empty");

  // Nothing is offered straight after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule

`default_nettype wire

// ----- verif/brb_ring_check_pkg.sv -----
`timescale 1ns / 1ps

package brb_ring_check_pkg;

  import brb_pkg::*;

  // One result beat as the block should present it.
  typedef struct {
    status_t           status;
    logic [BYTE_W-1:0] read_byte;
    logic              byte_valid;
    logic              last;
  } ring_beat_t;

  // Shadow of the byte ring, plus the queue of beats still owed by the block.
  class ring_scoreboard;

    logic [BYTE_W-1:0] ring_mem [CAPACITY];
    int unsigned       put_ptr;
    int unsigned       take_ptr;
    int unsigned       free_bytes;
    int unsigned       block_left;
    bit                block_taken;
    ring_beat_t        owed_beats[$];
    int unsigned       errors;
    int unsigned       status_beats;
    int unsigned       data_beats;
    int unsigned       put_wraps;

    function new();
      put_ptr     = 0;
      take_ptr    = 0;
      free_bytes  = CAPACITY;
      block_left  = 0;
      block_taken = 1'b0;
      errors      = 0;
      status_beats = 0;
      data_beats  = 0;
      put_wraps   = 0;
    endfunction

    function int unsigned held_bytes();
      return CAPACITY - free_bytes;
    endfunction

    function int unsigned pending();
      return owed_beats.size();
    endfunction

    function void owe_status(status_t st);
      ring_beat_t b;
      b.status     = st;
      b.read_byte  = '0;
      b.byte_valid = 1'b0;
      b.last       = 1'b1;
      owed_beats.push_back(b);
    endfunction

    // Store one byte at the put pointer, wrapping at the end of the ring.
    function void keep_byte(logic [BYTE_W-1:0] b);
      if (free_bytes == 0) return;
      ring_mem[put_ptr] = b;
      if (put_ptr == CAPACITY - 1) begin
        put_ptr = 0;
        put_wraps++;
      end else begin
        put_ptr++;
      end
      free_bytes--;
    endfunction

    // Work out the beats caused by one accepted input beat.
    function void note_item(logic op_i, logic first_i, logic [LEN_W-1:0] len_i,
                            logic [BYTE_W-1:0] data_i);
      int unsigned len;
      ring_beat_t  b;
      len = len_i;
      if (op_i == OP_WRITE) begin
        if (first_i) begin
          if (len == 0) begin
            block_left  = 0;
            block_taken = 1'b0;
            owe_status(ST_ZERO_LEN);
          end else if (len > MAX_BLOCK || len > free_bytes) begin
            block_left  = len - 1;
            block_taken = 1'b0;
            owe_status(ST_NO_SPACE);
          end else begin
            block_taken = 1'b1;
            block_left  = len - 1;
            keep_byte(data_i);
            owe_status(ST_OK);
          end
        end else if (block_left != 0) begin
          // Bytes of a refused block are counted off but not stored.
          block_left--;
          if (block_taken) keep_byte(data_i);
          if (block_left == 0) block_taken = 1'b0;
        end
      end else begin
        if (len == 0) begin
          owe_status(ST_OK);
        end else if (len > MAX_BLOCK || len > held_bytes()) begin
          owe_status(ST_NO_DATA);
        end else begin
          for (int unsigned k = 0; k < len; k++) begin
            b.status     = ST_OK;
            b.read_byte  = ring_mem[take_ptr];
            b.byte_valid = 1'b1;
            b.last       = (k + 1 == len);
            owed_beats.push_back(b);
            take_ptr = (take_ptr == CAPACITY - 1) ? 0 : take_ptr + 1;
          end
          free_bytes += len;
        end
      end
    endfunction

    // Print one line per mismatch; after a flood only the count goes on.
    task report(string what, int unsigned want, int unsigned got);
      if (errors < 40)
        $display("%0t ns: mismatch on %s, expected %0d, got %0d", $time, what, want, got);
      errors++;
    endtask

    // Compare one accepted output beat with the oldest owed beat.
    task check_beat(status_t st, logic [BYTE_W-1:0] rb, logic bv, logic lst);
      ring_beat_t w;
      if (owed_beats.size() == 0) begin
        report("unexpected beat, status", 0, st);
        return;
      end
      w = owed_beats.pop_front();
      if (w.byte_valid) data_beats++;
      else status_beats++;
      if (st !== w.status) report("status", w.status, st);
      if (rb !== w.read_byte) report("read_byte", w.read_byte, rb);
      if (bv !== w.byte_valid) report("byte_valid", w.byte_valid, bv);
      if (lst !== w.last) report("last", w.last, lst);
    endtask

  endclass

endpackage

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  import brb_pkg::*;
  import brb_ring_check_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 250;
  localparam int RANDOM_ITEMS = 350;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic              op;
  logic              first;
  logic [LEN_W-1:0]  block_length;
  logic [BYTE_W-1:0] data_byte;
  logic              out_valid;
  logic              out_stall;
  logic [1:0]        status;
  logic [BYTE_W-1:0] read_byte;
  logic              byte_valid;
  logic              last;

  ring_scoreboard sb = new();

  int unsigned items_taken = 0;
  int unsigned held_cycles = 0;
  int unsigned cycles = 0;
  bit          no_gaps = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;

  byte_ring_buffer_block_io dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .first        (first),
    .block_length (block_length),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .read_byte    (read_byte),
    .byte_valid   (byte_valid),
    .last         (last)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d beats still owed.", cycles, sb.pending());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Output monitor: checks each beat taken (valid high, stall low); counts input holds.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        sb.check_beat(status_t'(status), read_byte, byte_valid, last);
      if (in_valid && in_stall) held_cycles++;
    end
  end

  // Receiver: random stalls, a quiet stretch, and one long hold-off.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (no_gaps) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 33);
      end
    end
  end

  // Offer one input beat, with random idle cycles first, and wait until it is taken.
  task send_item(logic op_i, logic first_i, int unsigned len_i, logic [BYTE_W-1:0] data_i);
    while (!no_gaps && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    op           <= op_i;
    first        <= first_i;
    block_length <= LEN_W'(len_i);
    data_byte    <= data_i;
    do @(posedge clk); while (in_stall);
    sb.note_item(op_i, first_i, LEN_W'(len_i), data_i);
    items_taken++;
  endtask

  // Send a write block header of length len, then beats-1 further random bytes.
  task send_block(int unsigned len, int unsigned beats);
    for (int unsigned k = 0; k < beats; k++)
      send_item(OP_WRITE, k == 0, len, BYTE_W'($urandom_range(255)));
  endtask

  task send_read(int unsigned len);
    send_item(OP_READ, 1'b0, len, BYTE_W'($urandom_range(255)));
  endtask

  // Stimulus.
  initial begin
    int unsigned pick;
    int unsigned len;
    int unsigned seqs;

    rst          <= 1'b1;
    in_valid     <= 1'b0;
    op           <= OP_WRITE;
    first        <= 1'b0;
    block_length <= '0;
    data_byte    <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty reads, a zero-length write and a stray byte.
    send_read(0);
    send_read(1);
    send_item(OP_WRITE, 1'b1, 0, 8'h3C);
    send_item(OP_WRITE, 1'b0, 0, 8'hC3);
    // A short block with extreme byte values, then read it back whole.
    send_item(OP_WRITE, 1'b1, 3, 8'h00);
    send_item(OP_WRITE, 1'b0, 0, 8'hFF);
    send_item(OP_WRITE, 1'b0, 0, 8'hA5);
    send_read(3);
    // An over-long block is refused; a new header cuts its dropped bytes short.
    send_item(OP_WRITE, 1'b1, 127, 8'h5A);
    send_item(OP_WRITE, 1'b0, 0, 8'h5A);
    send_item(OP_WRITE, 1'b1, 65, 8'h11);
    // An accepted block cut short by a new header keeps its stored bytes.
    send_item(OP_WRITE, 1'b1, 4, 8'h01);
    send_item(OP_WRITE, 1'b0, 0, 8'h02);
    send_item(OP_WRITE, 1'b1, 1, 8'h7E);
    // A read while a block is open sees only whole stored bytes.
    send_item(OP_WRITE, 1'b1, 3, 8'h55);
    send_read(4);
    send_item(OP_WRITE, 1'b0, 0, 8'h66);
    send_item(OP_WRITE, 1'b0, 0, 8'h77);
    // Over-long and too-long reads, drain whatever is held, then read the empty ring.
    send_read(65);
    send_read(127);
    send_read(sb.held_bytes() + 1);
    send_read(sb.held_bytes());
    send_read(64);

    // Pressure: the receiver holds off while single-byte blocks and reads keep coming.
    hold_req = 1'b1;
    for (int i = 0; i < 30; i++) begin
      if (i % 5 == 4) send_read(1);
      else send_block(1, 1);
    end

    // Random sequences: mostly well-formed blocks and reads, some noise.
    seqs = 0;
    while (items_taken < RANDOM_ITEMS) begin
      no_gaps = (seqs >= 10 && seqs < 30);
      pick = $urandom_range(99);
      if (pick < 45 || (pick < 80 && sb.held_bytes() == 0)) begin
        len = ($urandom_range(99) < 85) ? $urandom_range(1, 16) : $urandom_range(17, 64);
        send_block(len, len);
      end else if (pick < 80) begin
        len = (sb.held_bytes() < 64) ? sb.held_bytes() : 64;
        if ($urandom_range(3) != 0) len = $urandom_range(1, len);
        send_read(len);
      end else if (pick < 85) begin
        send_read(0);
      end else if (pick < 89) begin
        if (sb.held_bytes() < 64) send_read($urandom_range(sb.held_bytes() + 1, 64));
        else send_read($urandom_range(65, 127));
      end else if (pick < 92) begin
        send_item(OP_WRITE, 1'b1, 0, BYTE_W'($urandom_range(255)));
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 3))
          send_item(OP_WRITE, 1'b0, $urandom_range(127), BYTE_W'($urandom_range(255)));
      end else if (pick < 98) begin
        len = $urandom_range(2, 16);
        send_block(len, $urandom_range(1, len - 1));
      end else begin
        send_block($urandom_range(65, 127), $urandom_range(1, 4));
      end
      seqs++;
    end
    no_gaps = 1'b0;

    // Let every owed beat arrive, then allow a few cycles for strays.
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d input beats, %0d status beats and %0d read bytes checked.",
             items_taken, sb.status_beats, sb.data_beats);
    $display("The write pointer wrapped %0d times; input was held off for %0d cycles.",
             sb.put_wraps, held_cycles);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches found.", sb.errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
